// ----- rtl/stable_insertion_sorter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Stable insertion sorter: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_INSERTION_SORTER_TOP_DEFINES_SVH
`define STABLE_INSERTION_SORTER_TOP_DEFINES_SVH

// Plain property that must hold at every clock edge out of reset.
`define SIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable insertion sorter: package
// Sizes, payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int SLOTS  = 64;
  localparam int KEY_W  = 24;
  localparam int IDX_W  = 6;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [KEY_W-1:0] distance_key;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] arrival_index;
    logic [KEY_W-1:0] sorted_key;
    logic             last_result;
    logic             overflowed;
  } out_item_t;

  // One store entry as held in the RAM
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic load_in;     // latch accepted request
    logic set_ovf;     // request dropped, store full
    logic rd_top;      // start scan: read top entry
    logic shift_down;  // move read entry up one slot, read next lower
    logic put_above;   // place new key above current slot
    logic put_zero;    // place new key in slot 0
    logic emit_clr;    // rewind emission pointer
    logic emit_rd;     // read entry for emission
    logic emit_ld;     // load output register
    logic set_close;   // set finished: empty store, clear overflow
  } sis_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_zero;
    logic key_gt;        // stored key read back is greater than new key
    logic last_in;       // held request closes the set
    logic out_taken;
    logic out_last_taken;
  } sis_sts_t;

endpackage

// ----- rtl/sis_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sis_datapath.sv -----
// ----------------------------------------------------------------------------
// Stable insertion sorter: datapath
// Sorted store RAM, fill count, overflow flag, scan pointers, output register.
// ----------------------------------------------------------------------------
`include "stable_insertion_sorter_top_defines.svh"

module sis_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sis_pkg::in_item_t    in_data_i,
  input  sis_pkg::sis_cmd_t    cmd_i,
  output sis_pkg::sis_sts_t    sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sis_pkg::out_item_t   out_data_o
);

  logic [sis_pkg::KEY_W-1:0]  key_q;
  logic                       last_q;
  logic [sis_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic                       ovf_q, ovf_d;
  logic [sis_pkg::ADDR_W-1:0] ptr_q, ptr_d;
  logic [sis_pkg::ADDR_W-1:0] k_q, k_d;
  logic                       out_valid_q, out_valid_d;
  sis_pkg::out_item_t         out_q;

  sis_pkg::entry_t            new_entry;
  sis_pkg::entry_t            rdata;
  logic [$bits(sis_pkg::entry_t)-1:0] ram_rdata;
  logic                       ram_we, ram_re;
  logic [sis_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  sis_pkg::entry_t            ram_wdata;
  logic [sis_pkg::ADDR_W-1:0] top_addr;
  logic                       emit_end;
  logic                       out_taken;

  assign new_entry = '{idx: sis_pkg::IDX_W'(fill_q), key: key_q};
  assign rdata     = ram_rdata;
  assign top_addr  = sis_pkg::ADDR_W'(fill_q - sis_pkg::CNT_W'(1));
  assign emit_end  = (sis_pkg::CNT_W'(k_q) + sis_pkg::CNT_W'(1)) == fill_q;
  assign out_taken = out_valid_q & ~out_stall_i;

  // RAM port steering
  assign ram_we    = cmd_i.shift_down | cmd_i.put_above | cmd_i.put_zero;
  assign ram_waddr = cmd_i.put_zero ? '0 : ptr_q + sis_pkg::ADDR_W'(1);
  assign ram_wdata = cmd_i.shift_down ? rdata : new_entry;
  assign ram_re    = cmd_i.rd_top | cmd_i.shift_down | cmd_i.emit_rd;

  always_comb begin
    if (cmd_i.rd_top) begin
      ram_raddr = top_addr;
    end else if (cmd_i.shift_down) begin
      ram_raddr = ptr_q - sis_pkg::ADDR_W'(1);
    end else begin
      ram_raddr = k_q;
    end
  end

  sis_ram #(
    .WIDTH ($bits(sis_pkg::entry_t)),
    .DEPTH (sis_pkg::SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    ptr_d  = ptr_q;
    k_d    = k_q;
    if (cmd_i.put_above || cmd_i.put_zero) begin
      fill_d = fill_q + sis_pkg::CNT_W'(1);
    end
    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.set_close) begin
      fill_d = '0;
      ovf_d  = 1'b0;
    end
    if (cmd_i.rd_top) begin
      ptr_d = top_addr;
    end else if (cmd_i.shift_down) begin
      ptr_d = ptr_q - sis_pkg::ADDR_W'(1);
    end
    if (cmd_i.emit_clr) begin
      k_d = '0;
    end else if (cmd_i.emit_ld) begin
      k_d = k_q + sis_pkg::ADDR_W'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.emit_ld) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    k_q   <= k_d;
    if (cmd_i.load_in) begin
      key_q  <= in_data_i.distance_key;
      last_q <= in_data_i.last_item;
    end
    if (cmd_i.emit_ld) begin
      out_q.arrival_index <= rdata.idx;
      out_q.sorted_key    <= rdata.key;
      out_q.last_result   <= emit_end;
      out_q.overflowed    <= ovf_q;
    end
  end

  assign sts_o.full           = fill_q == sis_pkg::CNT_W'(sis_pkg::SLOTS);
  assign sts_o.empty          = fill_q == '0;
  assign sts_o.ptr_zero       = ptr_q == '0;
  assign sts_o.key_gt         = rdata.key > key_q;
  assign sts_o.last_in        = last_q;
  assign sts_o.out_taken      = out_taken;
  assign sts_o.out_last_taken = out_taken & out_q.last_result;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SIS_ASSERT(a_fill_range, fill_q <= sis_pkg::CNT_W'(sis_pkg::SLOTS), "fill count beyond capacity")
  `SIS_ASSERT_IMP(a_no_overwrite, cmd_i.emit_ld, !out_valid_q, "output register overwritten")
  `SIS_ASSERT_IMP(a_put_room, cmd_i.put_above || cmd_i.put_zero, fill_q != sis_pkg::CNT_W'(sis_pkg::SLOTS), "insert into full store")

endmodule

// ----- rtl/sis_ctrl.sv -----
// ----------------------------------------------------------------------------
// Stable insertion sorter: controller
// Sequences accept, backward insertion scan and emission of the sorted set.
// ----------------------------------------------------------------------------
`include "stable_insertion_sorter_top_defines.svh"

module sis_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sis_pkg::sis_sts_t sts_i,
  output sis_pkg::sis_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_EMRD  = 3'd4;
  localparam logic [2:0] S_EMLD  = 3'd5;
  localparam logic [2:0] S_EMWT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] after_put;

  // where to go once a key is placed (or dropped)
  assign after_put = sts_i.last_in ? S_EMRD : S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (sts_i.full) begin
          cmd_o.set_ovf  = 1'b1;
          cmd_o.emit_clr = sts_i.last_in;
          state_d        = after_put;
        end else if (sts_i.empty) begin
          state_d = S_PUT;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.key_gt) begin
          cmd_o.shift_down = 1'b1;
          state_d          = sts_i.ptr_zero ? S_PUT : S_CMP;
        end else begin
          cmd_o.put_above = 1'b1;
          cmd_o.emit_clr  = sts_i.last_in;
          state_d         = after_put;
        end
      end
      S_PUT: begin
        cmd_o.put_zero = 1'b1;
        cmd_o.emit_clr = sts_i.last_in;
        state_d        = after_put;
      end
      S_EMRD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EMLD;
      end
      S_EMLD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = S_EMWT;
      end
      S_EMWT: begin
        if (sts_i.out_last_taken) begin
          cmd_o.set_close = 1'b1;
          state_d         = S_IDLE;
        end else if (sts_i.out_taken) begin
          state_d = S_EMRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  `SIS_ASSERT_IMP(a_scan_nonempty, state_q == S_CMP, !sts_i.empty, "scan over empty store")
  `SIS_ASSERT_IMP(a_emit_nonempty, state_q == S_EMRD, !sts_i.empty, "emission of empty set")
  `SIS_ASSERT_NXT(a_close_idle, sts_i.out_last_taken, state_q == S_IDLE && sts_i.empty, "set not closed after final result")

endmodule

// ----- rtl/stable_insertion_sorter_top.sv -----
// ----------------------------------------------------------------------------
// Stable insertion sorter: top level
// Collects a set of Q16.8 distance keys and streams them back in ascending order.
// ----------------------------------------------------------------------------
// Each input request carries one unsigned Q16.8 key; its arrival position in
// the set becomes its index. Keys are held sorted in a single-port-pair RAM of
// SLOTS entries; a new key goes above every stored key less than or equal to
// it, so equal keys keep arrival order. The request flagged last closes the
// set: the whole list is then sent out as (index, key) result requests in
// ascending order, the final one marked, and the store is emptied. Requests
// arriving while the store is full are dropped and every result of that set
// carries the overflow flag. Each input request is placed by a backward
// read-compare-write scan through the store RAM, one slot per cycle, down
// past the stored keys greater than the new one. Emission reads each result
// from the RAM, loads the output register and hands it over before the next.
// Input stall is held high from acceptance until the request is placed and,
// for a closing request, until the final result is taken. No clearing pass
// is needed after reset: only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module stable_insertion_sorter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sis_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sis_pkg::out_item_t  out_data_o
);

  sis_pkg::sis_cmd_t cmd;
  sis_pkg::sis_sts_t sts;

  // Sequencer: owns the input handshake and all step decisions
  sis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store, counters and output register
  sis_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
